>>> hw/rtl/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// shared types and constants for the server group selector
// ----------------------------------------------------------------------------
package sgs_pkg;
  localparam int GROUPS  = 4;
  localparam int SERVERS = 16;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int FW = $clog2(SERVERS + 1);
  localparam int AW = $clog2(GROUPS * SERVERS);
  localparam int DEPTH = GROUPS * SERVERS;
  localparam logic [7:0] FAIL_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0, OP_REPORT = 2'd1, OP_PICK = 2'd2, OP_LOAD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0, MODE_LEAST = 2'd1, MODE_FIRST = 2'd2, MODE_RR = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one table row: id, available, latency, fail count
  localparam int EW = 10 + 1 + 16 + 8;
  typedef struct packed {
    logic [9:0]  id;
    logic        up;
    logic [15:0] lat;
    logic [7:0]  fails;
  } entry_t;
endpackage

>>> hw/rtl/sgs_ram.sv
// ----------------------------------------------------------------------------
// sgs_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module sgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/server_group_selector.sv
// ----------------------------------------------------------------------------
// server_group_selector
// health-aware server selection over per-group server tables
// ----------------------------------------------------------------------------
// A request on the in channel (valid/ready) carries an opcode, group, server id,
// report outcome and latency; exactly one response (chosen_id, status) leaves on
// the out channel (out_valid/out_ready). The mode register is written through
// cfg_we/cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. The table lives in one ram with a registered read, so
// each filled entry is scanned via SCAN_WAIT, then SCAN. A miss at accept or a
// full load answers from idle, a load goes through WRITE, a manual select reads
// its entry via RD0 and RD0_WAIT, least latency and first mode selects scan and
// then read the chosen entry, a report or pick scans for the id. Round robin
// adds a restoring remainder on the subtractor and a second scan.
// One request is in flight at a time: ready is high only while idle, and it
// returns the cycle after the response has been taken.
// A stalled receiver holds the response in the output register.
// Reset clears control state, fills, picks, counters and mode register; entry
// contents need no clearing since only loaded entries are ever read.
// ----------------------------------------------------------------------------
module server_group_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  opcode,
  input  logic [1:0]  group,
  input  logic [9:0]  server_id,
  input  logic        success,
  input  logic [15:0] latency,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  chosen_id,
  output logic [1:0]  status
);
  import sgs_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SCAN, SCAN_WAIT, DIV, SCAN2, SCAN2_WAIT, RD0, RD0_WAIT, WRITE, DONE
  } state_t;

  state_t state;
  logic [7:0] modes;
  logic [FW-1:0] fill [GROUPS];
  logic [SW-1:0] picked [GROUPS];
  logic [31:0] rr [GROUPS];

  op_t op;
  logic [GW-1:0] grp;
  logic [9:0] rid;
  logic rok;
  logic [15:0] rlat;
  mode_t mode;
  logic [FW-1:0] n;
  logic [FW-1:0] idx;
  logic found;
  logic [SW-1:0] best;
  logic [15:0] low_lat;
  logic [FW-1:0] avail;
  logic [31:0] quo, rem;
  logic [5:0] step;
  entry_t hit;

  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  entry_t wentry, rentry;

  sgs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wentry),
    .raddr(raddr), .rdata(rentry)
  );

  function automatic logic [AW-1:0] addr_of(input logic [GW-1:0] g,
                                             input logic [SW-1:0] i);
    logic [AW:0] a;
    a = (AW+1)'(g) * (AW+1)'(SERVERS) + (AW+1)'(i);
    return a[AW-1:0];
  endfunction

  assign ready = (state == IDLE);
  logic [SW-1:0] idx_lo;
  assign idx_lo = idx[SW-1:0];
  // subtractor for the restoring remainder
  logic [32:0] trial;
  assign trial = {rem[31:0], quo[31]} - {(33-FW)'(0), avail};

  always_comb begin
    raddr = addr_of(grp, idx_lo);
    ram_we = (state == WRITE);
    waddr = addr_of(grp, best);
    wentry = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      modes <= '0;
      out_valid <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        fill[g] <= '0;
        picked[g] <= '0;
        rr[g] <= '0;
      end
    end else begin
      if (cfg_we) begin
        modes <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (valid) begin
            op <= op_t'(opcode);
            grp <= GW'(group);
            rid <= server_id;
            rok <= success;
            rlat <= latency;
            mode <= mode_t'(modes[2*GW'(group) +: 2]);
            n <= fill[GW'(group)];
            idx <= '0;
            found <= 1'b0;
            best <= '0;
            low_lat <= '0;
            avail <= '0;
            chosen_id <= '0;
            status <= ST_OK;
            if ({1'b0, group} >= 3'(GROUPS)) begin
              status <= ST_MISS;
              state <= DONE;
              out_valid <= 1'b1;
            end else if (op_t'(opcode) == OP_LOAD) begin
              if (fill[GW'(group)] >= FW'(SERVERS)) begin
                status <= ST_FULL;
                state <= DONE;
                out_valid <= 1'b1;
              end else begin
                best <= SW'(fill[GW'(group)]);
                hit <= '{id: server_id, up: 1'b0, lat: 16'd0, fails: 8'd0};
                fill[GW'(group)] <= fill[GW'(group)] + 1'b1;
                state <= WRITE;
              end
            end else if (fill[GW'(group)] == '0) begin
              status <= ST_MISS;
              state <= DONE;
              out_valid <= 1'b1;
            end else if (op_t'(opcode) == OP_SELECT &&
                         mode_t'(modes[2*GW'(group) +: 2]) == MODE_MANUAL) begin
              idx <= (FW'(picked[GW'(group)]) < fill[GW'(group)])
                     ? FW'(picked[GW'(group)]) : '0;
              state <= RD0;
            end else if (op_t'(opcode) == OP_PICK &&
                         mode_t'(modes[2*GW'(group) +: 2]) != MODE_MANUAL) begin
              status <= ST_MISS;
              state <= DONE;
              out_valid <= 1'b1;
            end else begin
              state <= SCAN_WAIT;
            end
          end
        end
        SCAN_WAIT: state <= SCAN;
        SCAN: begin
          // rentry holds entry idx
          logic stop;
          stop = 1'b0;
          if (op == OP_SELECT) begin
            if (rentry.up) begin
              avail <= avail + 1'b1;
              if (mode == MODE_LEAST && (!found || rentry.lat < low_lat)) begin
                best <= idx_lo;
                low_lat <= rentry.lat;
              end
              if (mode == MODE_FIRST && !found) begin
                best <= idx_lo;
              end
              found <= 1'b1;
            end
          end else if (rentry.id == rid) begin
            stop = 1'b1;
            best <= idx_lo;
            hit <= rentry;
          end
          if (stop) begin
            if (op == OP_PICK) begin
              picked[grp] <= idx_lo;
              state <= DONE;
              out_valid <= 1'b1;
            end else begin
              state <= WRITE;
              if (rok) begin
                hit <= '{id: rentry.id, up: 1'b1, lat: rlat, fails: 8'd0};
              end else begin
                hit.fails <= (rentry.fails != 8'hff) ? rentry.fails + 1'b1
                                                      : rentry.fails;
                if (((rentry.fails != 8'hff) ? rentry.fails + 1'b1
                                             : rentry.fails) >= FAIL_LIMIT) begin
                  hit.up <= 1'b0;
                end
              end
            end
          end else if (idx + 1'b1 >= n) begin
            if (op != OP_SELECT) begin
              status <= ST_MISS;
              state <= DONE;
              out_valid <= 1'b1;
            end else if (mode == MODE_RR) begin
              if (avail + FW'(rentry.up) == '0) begin
                idx <= '0;
                state <= RD0;
              end else begin
                avail <= avail + FW'(rentry.up);
                quo <= rr[grp];
                rem <= '0;
                step <= '0;
                state <= DIV;
              end
            end else begin
              // least latency or first: fall back to entry 0 if none up
              idx <= (found || rentry.up) ? FW'(
                (mode == MODE_FIRST && !found) ? idx_lo :
                (mode == MODE_LEAST && rentry.up && (!found || rentry.lat < low_lat))
                ? idx_lo : best) : '0;
              state <= RD0;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= SCAN_WAIT;
          end
        end
        DIV: begin
          quo <= {quo[30:0], ~trial[32]};
          rem <= trial[32] ? {rem[30:0], quo[31]} : trial[31:0];
          step <= step + 1'b1;
          if (step == 6'd31) begin
            rr[grp] <= rr[grp] + 32'd1;
            idx <= '0;
            state <= SCAN2_WAIT;
          end
        end
        SCAN2_WAIT: state <= SCAN2;
        SCAN2: begin
          // rem is the target index among available entries
          if (rentry.up && rem[FW-1:0] == '0) begin
            chosen_id <= rentry.id;
            state <= DONE;
            out_valid <= 1'b1;
          end else begin
            if (rentry.up) begin
              rem <= rem - 32'd1;
            end
            idx <= idx + 1'b1;
            state <= SCAN2_WAIT;
          end
        end
        RD0: state <= RD0_WAIT;
        RD0_WAIT: begin
          chosen_id <= rentry.id;
          state <= DONE;
          out_valid <= 1'b1;
        end
        WRITE: begin
          state <= DONE;
          out_valid <= 1'b1;
        end
        DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/sgs_checker.sv
// ----------------------------------------------------------------------------
// sgs_checker
// port-level checks for the server group selector
// ----------------------------------------------------------------------------
module sgs_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] chosen_id,
  input logic [1:0] status
);
  import sgs_pkg::*;

  // one request in flight: no new request while a response is pending
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("ready while response pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_id) && $stable(status))
    else $error("response changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid && ready |=> !ready) else $error("ready right after accept");

  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
endmodule

bind server_group_selector sgs_checker u_sgs_checker (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .out_valid(out_valid),
  .out_ready(out_ready), .chosen_id(chosen_id), .status(status)
);
